>>> design/cdf_weighted_index_sampler_assert.svh
// Assertion macros shared by the checker of the weighted index sampler.
// Depends on nothing; included by the checker file.
`ifndef CDF_WEIGHTED_INDEX_SAMPLER_ASSERT_SVH
`define CDF_WEIGHTED_INDEX_SAMPLER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CDFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define CDFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/cdfs_pkg.sv
// Shared types and constants of the weighted index sampler.
// No dependencies; imported by the sampler, its RAM-free logic and its checker.
package cdfs_pkg;

	localparam int REQ_W    = 2;
	localparam int WEIGHT_W = 24;
	localparam int POINT_W  = 24;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 10;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_BAD   = 2'd3;

	// Sequencer states, one-hot
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_MUL_LO = 5'b00010,
		ST_MUL_HI = 5'b00100,
		ST_ADDR   = 5'b01000,
		ST_CMP    = 5'b10000
	} state_t;

endpackage

>>> design/cdfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cdfs_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/cdf_weighted_index_sampler.sv
// Weighted index sampler: keeps running prefix sums of entry weights in a RAM and
// answers sample requests by an inverse-CDF binary search. A clear, an append, a
// sample on an empty table and an unused request code each give their result in
// the cycle after the transfer. A sample on a table of n entries first forms the
// threshold total_weight * sample_point on one shared 18-bit-wide multiplier,
// low slice of the total then high slice, then runs search steps (RAM read, then
// compare), at most ceil(log2 n) of them. Only one request is in work at a time;
// a new request is taken once the sequencer is idle and the result register is
// empty or being drained. The prefix sum RAM needs no clearing after reset: only
// entries below the entry count are ever read. Depends on cdfs_pkg and cdfs_ram.
module cdf_weighted_index_sampler #(
	parameter int MAX_ENTRIES = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [cdfs_pkg::REQ_W-1:0]      req_type,
	input  logic [cdfs_pkg::WEIGHT_W-1:0]   entry_weight,
	input  logic [cdfs_pkg::POINT_W-1:0]    sample_point,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [cdfs_pkg::STATUS_W-1:0]   status,
	output logic [cdfs_pkg::INDEX_W-1:0]    entry_index
);

	import cdfs_pkg::*;

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int SUM_W = WEIGHT_W + IDX_W;
	localparam int THR_W = SUM_W + POINT_W;
	localparam int LO_W  = 16;
	localparam int HI_W  = SUM_W - LO_W;
	localparam int MUL_W = (HI_W > LO_W) ? HI_W : LO_W;
	localparam int PRD_W = MUL_W + POINT_W;

	state_t state_q;

	logic [CNT_W-1:0]   cnt_q;
	logic [SUM_W-1:0]   total_q;
	logic [POINT_W-1:0] point_q;
	logic [THR_W-1:0]   thr_q;
	logic [IDX_W-1:0]   lo_q;
	logic [IDX_W-1:0]   hi_q;
	logic [IDX_W-1:0]   mid_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [INDEX_W-1:0]  index_q;

	logic               accept;
	logic               full;
	logic [SUM_W-1:0]   new_total;
	logic               ram_we;
	logic               ram_re;
	logic [SUM_W-1:0]   ram_rdata;
	logic [IDX_W:0]     mid_sum;
	logic [IDX_W-1:0]   mid_next;
	logic [MUL_W-1:0]   mul_a;
	logic [PRD_W-1:0]   mul_p;
	logic               below;
	logic [IDX_W+INDEX_W-1:0] lo_ext;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign full      = (cnt_q == CNT_W'(MAX_ENTRIES));
	assign new_total = total_q + SUM_W'(entry_weight);
	assign ram_we    = accept && (req_type == REQ_APPEND) && !full;

	// Midpoint of the current search window
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_next = mid_sum[IDX_W:1];
	assign ram_re   = (state_q == ST_ADDR) && (lo_q < hi_q);

	// Shared multiplier: low then high slice of the total against the fraction
	assign mul_a = (state_q == ST_MUL_LO) ? MUL_W'(total_q[LO_W-1:0])
	                                      : MUL_W'(total_q[SUM_W-1:LO_W]);
	assign mul_p = mul_a * PRD_W'(point_q);

	// Scaled prefix sum below the threshold: move the window up
	assign below  = ({ram_rdata, {POINT_W{1'b0}}} < thr_q);
	assign lo_ext = {{INDEX_W{1'b0}}, lo_q};

	cdfs_ram #(
		.WIDTH (SUM_W),
		.DEPTH (MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata (new_total),
		.re    (ram_re),
		.raddr (mid_next),
		.rdata (ram_rdata)
	);

	// Sequencer and table bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req_type == REQ_SAMPLE && cnt_q != '0) begin
							state_q <= ST_MUL_LO;
						end else begin
							out_valid_q <= 1'b1;
						end
						if (req_type == REQ_CLEAR) begin
							cnt_q   <= '0;
							total_q <= '0;
						end
						if (ram_we) begin
							cnt_q   <= cnt_q + CNT_W'(1);
							total_q <= new_total;
						end
					end
				end
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: state_q <= ST_ADDR;
				ST_ADDR: begin
					if (lo_q < hi_q) begin
						state_q <= ST_CMP;
					end else begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				ST_CMP: state_q <= ST_ADDR;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Search datapath and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					point_q  <= sample_point;
					lo_q     <= '0;
					hi_q     <= IDX_W'(cnt_q - CNT_W'(1));
					index_q  <= '0;
					status_q <= STAT_OK;
					if (req_type == REQ_APPEND && full) begin
						status_q <= STAT_FULL;
					end
					if (req_type == REQ_SAMPLE && cnt_q == '0) begin
						status_q <= STAT_EMPTY;
					end
				end
			end
			ST_MUL_LO: thr_q <= THR_W'(mul_p);
			ST_MUL_HI: thr_q <= thr_q + (THR_W'(mul_p) << LO_W);
			ST_ADDR: begin
				mid_q <= mid_next;
				if (!(lo_q < hi_q)) begin
					index_q <= lo_ext[INDEX_W-1:0];
				end
			end
			ST_CMP: begin
				if (below) begin
					lo_q <= mid_q + IDX_W'(1);
				end else begin
					hi_q <= mid_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_index = index_q;

endmodule

>>> design/cdfs_checker.sv
// Port-level checker of the weighted index sampler, bound to the top level.
// Depends on cdfs_pkg and cdf_weighted_index_sampler_assert.svh.
`include "cdf_weighted_index_sampler_assert.svh"

module cdfs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [cdfs_pkg::REQ_W-1:0]    req_type,
	input logic [cdfs_pkg::WEIGHT_W-1:0] entry_weight,
	input logic [cdfs_pkg::POINT_W-1:0]  sample_point,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [cdfs_pkg::STATUS_W-1:0] status,
	input logic [cdfs_pkg::INDEX_W-1:0]  entry_index
);

	import cdfs_pkg::*;

	// Hold a stalled result
	`CDFS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(entry_index), "result changed while stalled")

	// Any failed request reports entry zero
	`CDFS_ASSERT_NOW(a_fail_index, clk, arst_n, out_valid && status != STAT_OK, entry_index == '0, "failed request carries an index")

	// Block new requests while a result is held back
	`CDFS_ASSERT_NOW(a_stall_block, clk, arst_n, out_valid && !out_ready, !in_ready, "request taken over a stalled result")

	// Never report the unused status code
	`CDFS_ASSERT_NOW(a_no_bad_status, clk, arst_n, out_valid, status != STAT_BAD, "reserved status code reported")

endmodule

bind cdf_weighted_index_sampler cdfs_checker u_cdfs_checker (.*);
